// File: rtl/core/dpas_pkg.sv
package dpas_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned AmtW  = 5;

  // Opcodes, instruction bits 24..21
  localparam logic [3:0] OpAnd = 4'h0;
  localparam logic [3:0] OpEor = 4'h1;
  localparam logic [3:0] OpSub = 4'h2;
  localparam logic [3:0] OpRsb = 4'h3;
  localparam logic [3:0] OpAdd = 4'h4;
  localparam logic [3:0] OpAdc = 4'h5;
  localparam logic [3:0] OpSbc = 4'h6;
  localparam logic [3:0] OpRsc = 4'h7;
  localparam logic [3:0] OpTst = 4'h8;
  localparam logic [3:0] OpTeq = 4'h9;
  localparam logic [3:0] OpCmp = 4'hA;
  localparam logic [3:0] OpCmn = 4'hB;
  localparam logic [3:0] OpOrr = 4'hC;
  localparam logic [3:0] OpMov = 4'hD;
  localparam logic [3:0] OpBic = 4'hE;
  localparam logic [3:0] OpMvn = 4'hF;

  // Shift types, instruction bits 6..5
  localparam logic [1:0] ShLsl = 2'd0;
  localparam logic [1:0] ShLsr = 2'd1;
  localparam logic [1:0] ShAsr = 2'd2;
  localparam logic [1:0] ShRor = 2'd3;

  // Normalized shifter operations
  localparam logic [2:0] ModePass  = 3'd0; // value unchanged, carry from C flag
  localparam logic [2:0] ModeShift = 3'd1; // shift by 1..31
  localparam logic [2:0] ModeRrx   = 3'd2; // rotate right through carry
  localparam logic [2:0] ModeZero  = 3'd3; // logical shift beyond 32
  localparam logic [2:0] ModeLsl32 = 3'd4;
  localparam logic [2:0] ModeLsr32 = 3'd5;
  localparam logic [2:0] ModeAsr32 = 3'd6;
  localparam logic [2:0] ModeRor32 = 3'd7;

  localparam logic [3:0] RegPc = 4'hF;

  typedef struct packed {
    logic [2:0]       mode;
    logic [1:0]       kind;
    logic [AmtW-1:0]  amt;
    logic [WordW-1:0] src;
    logic             cin;
  } shift_ctl_t;

  typedef struct packed {
    logic [WordW-1:0] res;
    logic             c;
    logic             v;
    logic             no_dest;
  } alu_res_t;

  typedef struct packed {
    shift_ctl_t       sctl;
    logic [WordW-1:0] rn;
    logic [3:0]       op;
    logic             s;
    logic [3:0]       rd;
    logic             vin;
  } s1_t;

  typedef struct packed {
    logic [WordW-1:0] op2;
    logic             sc;
    logic             cin;
    logic [WordW-1:0] rn;
    logic [3:0]       op;
    logic             s;
    logic [3:0]       rd;
    logic             vin;
  } s2_t;

  typedef struct packed {
    logic [WordW-1:0] res;
    logic             c;
    logic             v;
    logic             dw;
    logic             fw;
    logic             rp;
    logic [3:0]       rd;
  } s3_t;

  typedef struct packed {
    logic [WordW-1:0] res;
    logic [3:0]       rd;
    logic             dw;
    logic             fw;
    logic [3:0]       flags;
    logic             rp;
  } s4_t;

endpackage

// File: rtl/core/dpas_shifter.sv
module dpas_shifter
  import dpas_pkg::*;
(
  input  shift_ctl_t       ctl,
  output logic [WordW-1:0] op2,
  output logic             carry
);

  logic [2*WordW-1:0] dbl;
  logic [AmtW-1:0]    lsl_idx;
  logic [AmtW-1:0]    rsh_idx;

  assign dbl     = {ctl.src, ctl.src} >> ctl.amt;
  assign lsl_idx = AmtW'(0) - ctl.amt;   // 32 - amt, amt is 1..31 here
  assign rsh_idx = ctl.amt - AmtW'(1);

  always_comb begin
    op2   = ctl.src;
    carry = ctl.cin;
    case (ctl.mode)
      ModePass: begin
        op2   = ctl.src;
        carry = ctl.cin;
      end
      ModeShift: begin
        case (ctl.kind)
          ShLsl: begin
            op2   = ctl.src << ctl.amt;
            carry = ctl.src[lsl_idx];
          end
          ShLsr: begin
            op2   = ctl.src >> ctl.amt;
            carry = ctl.src[rsh_idx];
          end
          ShAsr: begin
            op2   = WordW'($signed(ctl.src) >>> ctl.amt);
            carry = ctl.src[rsh_idx];
          end
          default: begin
            op2   = dbl[WordW-1:0];
            carry = ctl.src[rsh_idx];
          end
        endcase
      end
      ModeRrx: begin
        op2   = {ctl.cin, ctl.src[WordW-1:1]};
        carry = ctl.src[0];
      end
      ModeZero: begin
        op2   = '0;
        carry = 1'b0;
      end
      ModeLsl32: begin
        op2   = '0;
        carry = ctl.src[0];
      end
      ModeLsr32: begin
        op2   = '0;
        carry = ctl.src[WordW-1];
      end
      ModeAsr32: begin
        op2   = {WordW{ctl.src[WordW-1]}};
        carry = ctl.src[WordW-1];
      end
      default: begin
        op2   = ctl.src;
        carry = ctl.src[WordW-1];
      end
    endcase
  end

endmodule

// File: rtl/core/dpas_alu.sv
module dpas_alu
  import dpas_pkg::*;
(
  input  logic [3:0]       op,
  input  logic [WordW-1:0] rn,
  input  logic [WordW-1:0] op2,
  input  logic             sc,
  input  logic             cin,
  input  logic             vin,
  output alu_res_t         result
);

  logic [WordW-1:0] x;
  logic [WordW-1:0] y;
  logic             ci;
  logic             arith;
  logic [WordW:0]   sum;

  always_comb begin
    x     = rn;
    y     = op2;
    ci    = 1'b0;
    arith = 1'b1;
    case (op)
      OpSub, OpCmp: begin
        y  = ~op2;
        ci = 1'b1;
      end
      OpRsb: begin
        x  = op2;
        y  = ~rn;
        ci = 1'b1;
      end
      OpAdd, OpCmn: ci = 1'b0;
      OpAdc: ci = cin;
      OpSbc: begin
        y  = ~op2;
        ci = cin;
      end
      OpRsc: begin
        x  = op2;
        y  = ~rn;
        ci = cin;
      end
      default: arith = 1'b0;
    endcase
  end

  assign sum = {1'b0, x} + {1'b0, y} + {{WordW{1'b0}}, ci};

  always_comb begin
    result.res     = sum[WordW-1:0];
    result.c       = sum[WordW];
    result.v       = ~(x[WordW-1] ^ y[WordW-1]) & (x[WordW-1] ^ sum[WordW-1]);
    result.no_dest = (op == OpTst) || (op == OpTeq) || (op == OpCmp) || (op == OpCmn);
    if (!arith) begin
      result.c = sc;
      result.v = vin;
      case (op)
        OpAnd, OpTst: result.res = rn & op2;
        OpEor, OpTeq: result.res = rn ^ op2;
        OpOrr:        result.res = rn | op2;
        OpMov:        result.res = op2;
        OpBic:        result.res = rn & ~op2;
        default:      result.res = ~op2;
      endcase
    end
  end

endmodule

// File: rtl/core/data_processing_alu_with_shifter_unit.sv
// Data-processing execute unit: operand-2 barrel shifter followed by a
// 16-opcode ALU with NZCV flag generation.
//
// Input channel (in_*): one beat carries one instruction word together with
// the Rn, Rm and Rs-low-byte operand values and the current C and V flags.
// Result channel (out_*): one beat per input beat, in order, carrying the
// result, Rd, the register write enable, the flag write enable, the new
// flags and the PSR-restore request (S set with Rd = PC).
//
// Pipeline: four register stages (operand-2 decode, barrel shift, adder and
// logic, flag formation); each accepted input beat passes through all four
// before its result beat appears on out_tvalid. Throughput is one beat per cycle while out_tready is high;
// the carry chain of the 32-bit adder in stage 3 sets the cycle time.
//
// Each stage has its own valid bit and advances whenever the stage after it
// is empty or moving, so bubbles collapse and a stalled receiver only holds
// the stages that are full. Up to four beats sit in flight while out_tready
// is low; in_tready drops only once every stage is occupied.
//
// Reset (rst_n low, synchronous) empties all stages; payload is not cleared.
module data_processing_alu_with_shifter_unit
  import dpas_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [31:0] instr_word, [63:32] rn_value, [95:64] rm_value,
  // [103:96] rs_shift, [104] carry_in, [105] overflow_in, [111:106] zero
  input  logic [111:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [31:0] alu_result, [35:32] dest_index, [36] dest_write,
  // [37] flags_write, [41:38] flags_out, [42] restore_psr, [47:43] zero
  output logic [47:0]  out_tdata
);

  // Unpack the input beat
  logic [WordW-1:0] instr_word;
  logic [WordW-1:0] rn_value;
  logic [WordW-1:0] rm_value;
  logic [7:0]       rs_shift;
  logic             carry_in;
  logic             overflow_in;

  assign instr_word  = in_tdata[31:0];
  assign rn_value    = in_tdata[63:32];
  assign rm_value    = in_tdata[95:64];
  assign rs_shift    = in_tdata[103:96];
  assign carry_in    = in_tdata[104];
  assign overflow_in = in_tdata[105];

  // Stage valid bits and per-stage advance
  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  assign rdy4      = !v4_r || out_tready;
  assign rdy3      = !v3_r || rdy4;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  s1_t s1_nxt, s1_r;
  s2_t s2_nxt, s2_r;
  s3_t s3_nxt, s3_r;
  s4_t s4_nxt, s4_r;

  // Stage 1: decode operand 2 into a normalized shifter operation
  logic [1:0] sh_type;
  logic [7:0] sh_amt;
  logic       sh_reg;
  logic [4:0] rot;

  always_comb begin
    sh_reg  = instr_word[4];
    sh_type = instr_word[6:5];
    sh_amt  = sh_reg ? rs_shift : {3'b000, instr_word[11:7]};
    rot     = {instr_word[11:8], 1'b0};

    s1_nxt.rn       = rn_value;
    s1_nxt.op       = instr_word[24:21];
    s1_nxt.s        = instr_word[20];
    s1_nxt.rd       = instr_word[15:12];
    s1_nxt.vin      = overflow_in;
    s1_nxt.sctl.cin = carry_in;
    s1_nxt.sctl.src = rm_value;
    s1_nxt.sctl.kind = sh_type;
    s1_nxt.sctl.amt  = sh_amt[AmtW-1:0];
    s1_nxt.sctl.mode = ModeShift;

    if (instr_word[25]) begin
      // Rotated 8-bit immediate; a zero rotate keeps the C flag
      s1_nxt.sctl.src  = {24'h000000, instr_word[7:0]};
      s1_nxt.sctl.kind = ShRor;
      s1_nxt.sctl.amt  = rot;
      s1_nxt.sctl.mode = (rot == 5'd0) ? ModePass : ModeShift;
    end else if (sh_amt == 8'd0) begin
      if (sh_reg || sh_type == ShLsl) begin
        s1_nxt.sctl.mode = ModePass;
      end else if (sh_type == ShRor) begin
        s1_nxt.sctl.mode = ModeRrx;
      end else if (sh_type == ShLsr) begin
        s1_nxt.sctl.mode = ModeLsr32;
      end else begin
        s1_nxt.sctl.mode = ModeAsr32;
      end
    end else begin
      case (sh_type)
        ShLsl: begin
          if (sh_amt < 8'd32) begin
            s1_nxt.sctl.mode = ModeShift;
          end else if (sh_amt == 8'd32) begin
            s1_nxt.sctl.mode = ModeLsl32;
          end else begin
            s1_nxt.sctl.mode = ModeZero;
          end
        end
        ShLsr: begin
          if (sh_amt < 8'd32) begin
            s1_nxt.sctl.mode = ModeShift;
          end else if (sh_amt == 8'd32) begin
            s1_nxt.sctl.mode = ModeLsr32;
          end else begin
            s1_nxt.sctl.mode = ModeZero;
          end
        end
        ShAsr: begin
          s1_nxt.sctl.mode = (sh_amt < 8'd32) ? ModeShift : ModeAsr32;
        end
        default: begin
          // Rotation by a nonzero multiple of 32 leaves Rm, carry from bit 31
          s1_nxt.sctl.mode = (sh_amt[4:0] == 5'd0) ? ModeRor32 : ModeShift;
        end
      endcase
    end
  end

  // Stage 2: barrel shift
  logic [WordW-1:0] op2;
  logic             sh_carry;

  dpas_shifter u_shifter (
    .ctl   (s1_r.sctl),
    .op2   (op2),
    .carry (sh_carry)
  );

  always_comb begin
    s2_nxt.op2 = op2;
    s2_nxt.sc  = sh_carry;
    s2_nxt.cin = s1_r.sctl.cin;
    s2_nxt.rn  = s1_r.rn;
    s2_nxt.op  = s1_r.op;
    s2_nxt.s   = s1_r.s;
    s2_nxt.rd  = s1_r.rd;
    s2_nxt.vin = s1_r.vin;
  end

  // Stage 3: adder and logic
  alu_res_t alu_out;

  dpas_alu u_alu (
    .op     (s2_r.op),
    .rn     (s2_r.rn),
    .op2    (s2_r.op2),
    .sc     (s2_r.sc),
    .cin    (s2_r.cin),
    .vin    (s2_r.vin),
    .result (alu_out)
  );

  always_comb begin
    s3_nxt.res = alu_out.res;
    s3_nxt.c   = alu_out.c;
    s3_nxt.v   = alu_out.v;
    s3_nxt.dw  = !alu_out.no_dest;
    s3_nxt.fw  = s2_r.s && (s2_r.rd != RegPc);
    s3_nxt.rp  = s2_r.s && (s2_r.rd == RegPc);
    s3_nxt.rd  = s2_r.rd;
  end

  // Stage 4: flag formation; flags read zero when not written
  always_comb begin
    s4_nxt.res   = s3_r.res;
    s4_nxt.rd    = s3_r.rd;
    s4_nxt.dw    = s3_r.dw;
    s4_nxt.fw    = s3_r.fw;
    s4_nxt.rp    = s3_r.rp;
    s4_nxt.flags = s3_r.fw ? {s3_r.res[WordW-1], s3_r.res == '0, s3_r.c, s3_r.v} : 4'h0;
  end

  // Valid bits: advance where the next stage has room, drop on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_tvalid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  // Payload: load only when the stage takes a real beat
  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) s1_r <= s1_nxt;
    if (rdy2 && v1_r)      s2_r <= s2_nxt;
    if (rdy3 && v2_r)      s3_r <= s3_nxt;
    if (rdy4 && v3_r)      s4_r <= s4_nxt;
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = {5'b00000, s4_r.rp, s4_r.flags, s4_r.fw, s4_r.dw, s4_r.rd, s4_r.res};

`ifndef SYNTH
  a_no_fw_and_rp: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[37] && out_tdata[42]))
    else $error("flag write and PSR restore both set");

  a_flags_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[37] |-> out_tdata[41:38] == 4'h0)
    else $error("flags nonzero without flag write");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !rdy2 |=> v1_r && $stable(s1_r))
    else $error("stage 1 beat lost during stall");

  a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !rdy4 |=> v3_r && $stable(s3_r))
    else $error("stage 3 beat lost during stall");

  a_ready_when_room: assert property (@(posedge clk) disable iff (!rst_n)
    !(v1_r && v2_r && v3_r && v4_r) |-> in_tready)
    else $error("input stalled with an empty stage");
`endif

endmodule
